### hw/rtl/wbtp_pkg.sv
// Package for the weighted book table probe: widths, entry layout, request and status codes.
// Used by weighted_book_table_probe and by its checker. No dependencies.
`timescale 1ns / 1ps

package wbtp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 16;
    localparam int WGT_W   = 16;
    localparam int RAND_W  = 32;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = WGT_W + CNT_W;
    localparam int PROD_W  = RAND_W + TOTAL_W;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PROBE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MOVE_W-1:0] move;
        logic [WGT_W-1:0]  weight;
    } entry_t;

endpackage

### hw/rtl/weighted_book_table_probe.sv
// Weighted book table probe: a flat entry table in one synchronous memory, with
// clear, insert and weighted probe requests. Depends on wbtp_pkg.
`timescale 1ns / 1ps

// Channel   Ports                                                     Handshake
// request   action, position_key, move_word, entry_weight,            start, busy
//           random_value
// result    status, chosen_move, has_moves                            done
//
// Clear, insert and unused codes are answered straight from idle: done rises on the next cycle
// and busy stays low, so a new request can follow at once.
// A probe holds busy until its result is out, and done rises in the cycle that busy falls.
// The entry memory has one read port, and both passes (weight sum, then selection)
// stream it one entry a cycle. The selection pass stops at the chosen entry. A key
// that is absent or has a zero total weight skips it. Reset empties the table at
// once; results cannot be stalled.
module weighted_book_table_probe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [wbtp_pkg::ACT_W-1:0]  action,
    input  logic [wbtp_pkg::KEY_W-1:0]  position_key,
    input  logic [wbtp_pkg::MOVE_W-1:0] move_word,
    input  logic [wbtp_pkg::WGT_W-1:0]  entry_weight,
    input  logic [wbtp_pkg::RAND_W-1:0] random_value,
    output logic                        done,
    output logic [wbtp_pkg::STAT_W-1:0] status,
    output logic [wbtp_pkg::MOVE_W-1:0] chosen_move,
    output logic                        has_moves
);

    import wbtp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_PICK
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                vld_reg;
    entry_t              rd_data_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [RAND_W-1:0]   rand_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  pick_reg;
    logic [TOTAL_W-1:0]  run_reg;
    logic                found_reg;
    logic [MOVE_W-1:0]   first_move_reg;
    logic                done_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [MOVE_W-1:0]   chosen_move_reg;
    logic                has_moves_reg;

    entry_t              mem [TABLE_DEPTH];

    logic                accept;
    logic                wr_en;
    logic                table_full;
    logic                hit;
    logic                pass_end;
    logic [TOTAL_W-1:0]  run_next;
    logic [PROD_W-1:0]   product;

    assign accept     = start && (state_reg == ST_IDLE);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en      = accept && (action == ACT_INSERT) && !table_full;
    assign hit        = vld_reg && (rd_data_reg.key == key_reg);
    // The pass ends once every entry has been issued and the last read is consumed.
    assign pass_end   = (idx_reg == count_reg) && !vld_reg;
    assign run_next   = run_reg + TOTAL_W'(rd_data_reg.weight);
    assign product    = PROD_W'(rand_reg) * PROD_W'(total_reg);

    // Entry memory: one write port for inserts, one registered read port for the passes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= '{key: position_key, move: move_word,
                                            weight: entry_weight};
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            vld_reg         <= 1'b0;
            found_reg       <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= STAT_DONE;
            chosen_move_reg <= '0;
            has_moves_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (action)
                            ACT_CLEAR:
                            begin
                                count_reg       <= '0;
                                done_reg        <= 1'b1;
                                status_reg      <= STAT_DONE;
                                chosen_move_reg <= '0;
                                has_moves_reg   <= 1'b0;
                            end
                            ACT_INSERT:
                            begin
                                if (!table_full)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                done_reg        <= 1'b1;
                                status_reg      <= table_full ? STAT_FULL : STAT_DONE;
                                chosen_move_reg <= '0;
                                has_moves_reg   <= 1'b0;
                            end
                            ACT_PROBE:
                            begin
                                key_reg   <= position_key;
                                rand_reg  <= random_value;
                                idx_reg   <= '0;
                                vld_reg   <= 1'b0;
                                total_reg <= '0;
                                found_reg <= 1'b0;
                                state_reg <= ST_SUM;
                            end
                            default:
                            begin
                                done_reg        <= 1'b1;
                                status_reg      <= STAT_DONE;
                                chosen_move_reg <= '0;
                                has_moves_reg   <= 1'b0;
                            end
                        endcase
                    end
                end

                ST_SUM:
                begin
                    if (idx_reg != count_reg)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                        vld_reg <= 1'b1;
                    end
                    else
                    begin
                        vld_reg <= 1'b0;
                    end
                    if (hit)
                    begin
                        total_reg <= total_reg + TOTAL_W'(rd_data_reg.weight);
                        if (!found_reg)
                        begin
                            found_reg      <= 1'b1;
                            first_move_reg <= rd_data_reg.move;
                        end
                    end
                    if (pass_end)
                    begin
                        if (!found_reg)
                        begin
                            done_reg        <= 1'b1;
                            status_reg      <= STAT_ABSENT;
                            chosen_move_reg <= '0;
                            has_moves_reg   <= 1'b0;
                            state_reg       <= ST_IDLE;
                        end
                        else if (total_reg == '0)
                        begin
                            done_reg        <= 1'b1;
                            status_reg      <= STAT_FOUND;
                            chosen_move_reg <= first_move_reg;
                            has_moves_reg   <= 1'b1;
                            state_reg       <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SCALE;
                        end
                    end
                end

                ST_SCALE:
                begin
                    pick_reg  <= product[RAND_W +: TOTAL_W];
                    run_reg   <= '0;
                    idx_reg   <= '0;
                    vld_reg   <= 1'b0;
                    state_reg <= ST_PICK;
                end

                ST_PICK:
                begin
                    if (idx_reg != count_reg)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                        vld_reg <= 1'b1;
                    end
                    else
                    begin
                        vld_reg <= 1'b0;
                    end
                    if (hit)
                    begin
                        run_reg <= run_next;
                    end
                    if (hit && (run_next > pick_reg))
                    begin
                        done_reg        <= 1'b1;
                        status_reg      <= STAT_FOUND;
                        chosen_move_reg <= rd_data_reg.move;
                        has_moves_reg   <= 1'b1;
                        vld_reg         <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                    else if (pass_end)
                    begin
                        // Pick always lies below the total, so this is only a safe fallback.
                        done_reg        <= 1'b1;
                        status_reg      <= STAT_FOUND;
                        chosen_move_reg <= first_move_reg;
                        has_moves_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign chosen_move = chosen_move_reg;
    assign has_moves   = has_moves_reg;

endmodule

### hw/rtl/wbtp_checker.sv
// Port-level checker for weighted_book_table_probe, attached by the bind below.
// Depends on wbtp_pkg for the status codes.
`timescale 1ns / 1ps

module wbtp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [wbtp_pkg::STAT_W-1:0] status,
    input logic [wbtp_pkg::MOVE_W-1:0] chosen_move,
    input logic                        has_moves
);

    import wbtp_pkg::*;

    // Every accepted request either answers on the next cycle or starts a probe.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request neither answered nor started a probe");

    // A probe never ends without a result.
    a_probe_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("probe finished without a result");

    a_found_has_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FOUND)) |-> has_moves)
        else $error("found result without has_moves");

    a_other_results_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_FOUND)) |-> ((chosen_move == '0) && !has_moves))
        else $error("non-found result carries a move");

endmodule

bind weighted_book_table_probe wbtp_checker u_wbtp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .chosen_move (chosen_move),
    .has_moves   (has_moves)
);
